// ----- hw/rtl/lld_pkg.sv -----
// Package for the least-loaded dispatcher: payload structs, controller
// state and command types, and fixed constants.
// No dependencies.
package lld_pkg;

   localparam int ACTIVE_W = 5;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam int OUT_IDX_W = 4;
   localparam int OUT_LOAD_W = 32;

   typedef struct packed {
      logic [15:0] job_weight;
      logic        last_in_batch;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0]  server_index;
      logic [COUNT_W-1:0]    slot_position;
      logic [OUT_LOAD_W-1:0] new_load;
      logic                  batch_end;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // latch the request payload
      logic commit;   // update the winner (or clear the batch) and load the result
   } ctl_cmd_type;

endpackage

// ----- hw/rtl/lld_ctrl.sv -----
// Controller for the least-loaded dispatcher: sequences capture, tree
// settling and commit, and owns the result valid flag.
// Depends on lld_pkg.
module lld_ctrl #(
   parameter int SEARCH_CYCLES = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lld_pkg::ctl_cmd_type cmd
);
   import lld_pkg::*;

   localparam int CNT_W = (SEARCH_CYCLES > 1) ? $clog2(SEARCH_CYCLES) : 1;

   ctl_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      // The result register can take a new result if it is empty or
      // being drained in this cycle.
      out_free    = !rsp_valid_ff || rsp_ready;
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = CNT_W'(SEARCH_CYCLES - 1);
               state_in    = (SEARCH_CYCLES == 0) ? ST_COMMIT : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (cnt_ff == '0) begin
               state_in = ST_COMMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  cnt_in      = CNT_W'(SEARCH_CYCLES - 1);
                  state_in    = (SEARCH_CYCLES == 0) ? ST_COMMIT : ST_SEARCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/lld_datapath.sv -----
// Datapath for the least-loaded dispatcher: load and count registers,
// pipelined argmin tree, saturating update and result register.
// Depends on lld_pkg.
module lld_datapath #(
   parameter int MAX_SERVERS = 16,
   parameter int LOAD_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lld_pkg::ctl_cmd_type                cmd,
   input  lld_pkg::req_type                    req_payload,
   input  logic                                csr_write,
   input  logic [lld_pkg::ACTIVE_W-1:0]        csr_active_servers,
   output lld_pkg::rsp_type                    rsp_payload
);
   import lld_pkg::*;

   localparam int IDX_W = $clog2(MAX_SERVERS);
   localparam int LVL   = IDX_W;
   localparam int P     = 1 << IDX_W;

   typedef struct packed {
      logic                  ok;
      logic [LOAD_WIDTH-1:0] load;
      logic [COUNT_W-1:0]    count;
      logic [IDX_W-1:0]      idx;
   } node_type;

   logic [ACTIVE_W-1:0]   active_ff;
   logic [LOAD_WIDTH-1:0] load_ff  [MAX_SERVERS];
   logic [COUNT_W-1:0]    count_ff [MAX_SERVERS];
   req_type               job_ff;
   rsp_type               rsp_ff;

   node_type node_val [1:2*P-1];
   node_type cmp_val  [1:P-1];
   node_type node_ff  [1:P-1];

   node_type              win;
   logic [LOAD_WIDTH:0]   sum;
   logic [LOAD_WIDTH-1:0] sat_load;
   logic [COUNT_W-1:0]    next_count;
   logic [IDX_W+OUT_IDX_W-1:0]       idx_ext;
   logic [LOAD_WIDTH+OUT_LOAD_W-1:0] load_ext;

   // Tree levels are counted from the leaves; every second level is registered.
   function automatic logic node_is_reg(input int k);
      int d;
      d = 0;
      for (int b = 1; b <= LVL; b++) begin
         if (k >= (1 << b)) begin
            d = b;
         end
      end
      return ((LVL - d) & 1) == 0;
   endfunction

   always_comb begin
      for (int i = 0; i < P; i++) begin
         if (i < MAX_SERVERS) begin
            node_val[P+i].ok    = (i == 0) || (i < int'(active_ff));
            node_val[P+i].load  = load_ff[i];
            node_val[P+i].count = count_ff[i];
         end else begin
            node_val[P+i].ok    = 1'b0;
            node_val[P+i].load  = '0;
            node_val[P+i].count = '0;
         end
         node_val[P+i].idx = IDX_W'(i);
      end
      // Ties keep the left child, which holds the lower server index.
      for (int k = P - 1; k >= 1; k--) begin
         if (node_val[2*k+1].ok &&
             (!node_val[2*k].ok || node_val[2*k+1].load < node_val[2*k].load)) begin
            cmp_val[k] = node_val[2*k+1];
         end else begin
            cmp_val[k] = node_val[2*k];
         end
         node_val[k] = node_is_reg(k) ? node_ff[k] : cmp_val[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k < P; k++) begin
         node_ff[k] <= cmp_val[k];
      end
   end

   always_comb begin
      win        = node_val[1];
      sum        = {1'b0, win.load} + (LOAD_WIDTH + 1)'(job_ff.job_weight);
      sat_load   = sum[LOAD_WIDTH] ? '1 : sum[LOAD_WIDTH-1:0];
      next_count = (win.count == COUNT_MAX) ? win.count : win.count + 1'b1;
      idx_ext    = {{OUT_IDX_W{1'b0}}, win.idx};
      load_ext   = {{OUT_LOAD_W{1'b0}}, sat_load};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         for (int i = 0; i < MAX_SERVERS; i++) begin
            load_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            active_ff <= csr_active_servers;
         end
         if (cmd.commit) begin
            for (int i = 0; i < MAX_SERVERS; i++) begin
               if (job_ff.last_in_batch) begin
                  load_ff[i]  <= '0;
                  count_ff[i] <= '0;
               end else if (IDX_W'(i) == win.idx) begin
                  load_ff[i]  <= sat_load;
                  count_ff[i] <= next_count;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         job_ff <= req_payload;
      end
      if (cmd.commit) begin
         rsp_ff.server_index  <= idx_ext[OUT_IDX_W-1:0];
         rsp_ff.slot_position <= win.count;
         rsp_ff.new_load      <= load_ext[OUT_LOAD_W-1:0];
         rsp_ff.batch_end     <= job_ff.last_in_batch;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- hw/rtl/least_loaded_dispatcher_top.sv -----
// Top level of the least-loaded dispatcher.
// Depends on lld_pkg, lld_ctrl and lld_datapath.
//
// Usage: each transfer on the req_ channel carries one job weight and a
// last-in-batch flag. The block picks, among the active servers, the one
// with the smallest accumulated load (the lowest index wins on equal
// loads), adds the weight with saturation and returns one result on the
// rsp_ channel: server index, the job's slot in that server's list, new load
// and the batch_end flag. A job flagged last clears all loads and counts
// after it is handled. The csr_ channel writes the active server count;
// writes are always accepted and are meant to happen while the block is idle.
//
// The block takes no new job before the current one commits; the register
// stages of the argmin tree must first settle on the updated loads.
// Reset clears all loads and counts and sets the active count to sixteen.
// If the receiver stalls, the result is held in the output register and the
// next request is still taken; its commit waits until the result is taken.
module least_loaded_dispatcher_top #(
   parameter int MAX_SERVERS = 16,
   parameter int LOAD_WIDTH  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lld_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lld_pkg::rsp_type             rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lld_pkg::ACTIVE_W-1:0] csr_active_servers
);
   import lld_pkg::*;

   // Number of registered levels in the argmin tree.
   localparam int SEARCH_CYCLES = $clog2(MAX_SERVERS) / 2;

   ctl_cmd_type cmd;
   logic        csr_write;

   // The register write needs no wait state, so the port is always ready.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   lld_ctrl #(
      .SEARCH_CYCLES(SEARCH_CYCLES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd)
   );

   lld_datapath #(
      .MAX_SERVERS(MAX_SERVERS),
      .LOAD_WIDTH (LOAD_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_payload       (req_payload),
      .csr_write         (csr_write),
      .csr_active_servers(csr_active_servers),
      .rsp_payload       (rsp_payload)
   );

endmodule
